// ===== design/pidd_pkg.sv =====
// ----------------------------------------------------------------------------
// pidd_pkg
// Shared types and constants of the pixel id-pair deduplicator.
// ----------------------------------------------------------------------------
package pidd_pkg;

	// Multiplier of the key hash, split into 32-bit halves.
	localparam logic [31:0] HASH_MUL_LO = 32'hED55_8CCD;
	localparam logic [31:0] HASH_MUL_HI = 32'hFF51_AFD7;

	// Primitive id that marks a background pixel.
	localparam logic signed [31:0] BG_PRIM = -32'sd1;

	localparam int KEY_W    = 64;
	localparam int INDEX_W  = 10;
	localparam int COUNT_W  = 11;
	localparam int EPOCH_W  = 8;

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [EPOCH_W-1:0] epoch_t;

	// One table slot. A slot is occupied when its tag equals the current epoch.
	typedef struct packed {
		key_t   key;
		index_t idx;
		epoch_t tag;
	} slot_entry_t;

	typedef struct packed {
		logic   frame;
		logic   lookup;
		key_t   key;
		count_t limit;
	} tbl_req_t;

	typedef struct packed {
		logic   done;
		index_t index;
		logic   added;
	} tbl_rsp_t;

	typedef struct packed {
		logic sweeping;
		logic overflow;
	} tbl_status_t;

endpackage

// ===== design/pixel_id_pair_deduplicator.sv =====
// ----------------------------------------------------------------------------
// pixel_id_pair_deduplicator
// Background pixel: done strobes from state T_BG once start is taken. Other pixels pass
// T_HASH, T_ISSUE and T_LOOK (hash, wait for any clearing pass, probe the table).
// One pixel at a time; the next is taken in the cycle done strobes unless busy is high;
// results never stall. Reset and every 255th frame start run a clearing pass over all TABLE_SLOTS slots, busy high.
// ----------------------------------------------------------------------------
module pixel_id_pair_deduplicator #(
	parameter int MAX_PAIRS   = 1024,
	parameter int TABLE_SLOTS = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           frame_start,
	input  logic signed [31:0]             prim_id,
	input  logic signed [31:0]             inst_id,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pidd_pkg::COUNT_W-1:0]   cfg_data,
	output logic                           done,
	output logic [pidd_pkg::INDEX_W-1:0]   identity_index,
	output logic                           is_background,
	output logic                           newly_added,
	output logic                           overflow
);

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam pidd_pkg::count_t PAIR_CAP =
		(MAX_PAIRS > 2047) ? pidd_pkg::COUNT_W'(2047) : pidd_pkg::COUNT_W'(MAX_PAIRS);
	localparam pidd_pkg::count_t LIMIT_RESET = pidd_pkg::COUNT_W'(1024);

	localparam logic [2:0] T_IDLE  = 3'd0;
	localparam logic [2:0] T_BG    = 3'd1;
	localparam logic [2:0] T_HASH  = 3'd2;
	localparam logic [2:0] T_ISSUE = 3'd3;
	localparam logic [2:0] T_LOOK  = 3'd4;

	logic [2:0]             st_q;
	pidd_pkg::count_t       limit_cfg_q;
	logic                   done_q;
	pidd_pkg::key_t         key_q;
	logic [SW-1:0]          slot_q;
	pidd_pkg::index_t       index_q;
	logic                   bg_q;
	logic                   added_q;
	logic                   ovf_out_q;

	logic                   accept;
	logic                   bg_in;
	pidd_pkg::key_t         key_in;
	pidd_pkg::count_t       limit;
	logic                   hash_done;
	logic [SW-1:0]          hash_slot;
	pidd_pkg::tbl_req_t     tbl_req;
	pidd_pkg::tbl_rsp_t     tbl_rsp;
	pidd_pkg::tbl_status_t  tbl_status;

	assign busy      = (st_q != T_IDLE) || tbl_status.sweeping;
	assign accept    = start && !busy;
	assign bg_in     = prim_id == pidd_pkg::BG_PRIM;
	assign key_in    = {prim_id, inst_id};
	assign limit     = (limit_cfg_q > PAIR_CAP) ? PAIR_CAP : limit_cfg_q;
	assign cfg_ready = 1'b1;

	assign tbl_req.frame  = accept && frame_start;
	assign tbl_req.lookup = (st_q == T_ISSUE) && !tbl_status.sweeping;
	assign tbl_req.key    = key_q;
	assign tbl_req.limit  = limit;

	pidd_hash #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept && !bg_in),
		.key   (key_in),
		.done  (hash_done),
		.slot  (hash_slot)
	);

	pidd_table #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (tbl_req),
		.home_slot(slot_q),
		.rsp      (tbl_rsp),
		.status   (tbl_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_IDLE;
			limit_cfg_q <= LIMIT_RESET;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				limit_cfg_q <= cfg_data;
			end
			unique case (st_q)
				T_IDLE: begin
					if (accept) begin
						st_q <= bg_in ? T_BG : T_HASH;
					end
				end
				T_BG: begin
					done_q <= 1'b1;
					st_q   <= T_IDLE;
				end
				T_HASH: begin
					if (hash_done) begin
						st_q <= T_ISSUE;
					end
				end
				// A frame start may have begun a clearing pass; wait for it.
				T_ISSUE: begin
					if (!tbl_status.sweeping) begin
						st_q <= T_LOOK;
					end
				end
				T_LOOK: begin
					if (tbl_rsp.done) begin
						done_q <= 1'b1;
						st_q   <= T_IDLE;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key_in;
		end
		if (st_q == T_HASH && hash_done) begin
			slot_q <= hash_slot;
		end
		if (st_q == T_BG) begin
			index_q   <= '0;
			bg_q      <= 1'b1;
			added_q   <= 1'b0;
			ovf_out_q <= tbl_status.overflow;
		end else if (st_q == T_LOOK && tbl_rsp.done) begin
			index_q   <= tbl_rsp.index;
			bg_q      <= 1'b0;
			added_q   <= tbl_rsp.added;
			ovf_out_q <= tbl_status.overflow;
		end
	end

	assign done           = done_q;
	assign identity_index = index_q;
	assign is_background  = bg_q;
	assign newly_added    = added_q;
	assign overflow       = ovf_out_q;

endmodule

// ===== design/pidd_hash.sv =====
// ----------------------------------------------------------------------------
// pidd_hash
// Home slot of a key: shift-xor, a 64-bit multiply by a constant built from
// three 32-bit partial products on one shared multiplier, shift-xor, then the
// low 32 bits reduced modulo the table size. For a table size that is not a
// power of two the reduction uses a reciprocal multiply on the same multiplier
// and one final compare and subtract.
// ----------------------------------------------------------------------------
module pidd_hash #(
	parameter int TABLE_SLOTS = 2048,
	localparam int SW = $clog2(TABLE_SLOTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pidd_pkg::key_t      key,
	output logic                done,
	output logic [SW-1:0]       slot
);

	localparam logic          POW2    = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
	localparam logic [SW:0]   MODULUS = (SW+1)'(TABLE_SLOTS);
	// Floor of 2^32 over the table size. The quotient it gives is at most one
	// short, so the remainder left over is below twice the table size.
	localparam logic [31:0]   RECIP   = 32'(64'h1_0000_0000 / 64'(TABLE_SLOTS));
	localparam logic [31:0]   SLOTS32 = 32'(TABLE_SLOTS);

	localparam logic [2:0] H_IDLE = 3'd0;
	localparam logic [2:0] H_MUL0 = 3'd1;
	localparam logic [2:0] H_MUL1 = 3'd2;
	localparam logic [2:0] H_MUL2 = 3'd3;
	localparam logic [2:0] H_FOLD = 3'd4;
	localparam logic [2:0] H_QUOT = 3'd5;
	localparam logic [2:0] H_PROD = 3'd6;
	localparam logic [2:0] H_FIX  = 3'd7;

	logic [2:0]  state_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] p_q;
	logic [31:0] h_q;
	logic [31:0] q_q;
	logic [SW:0] rem_q;
	logic [SW-1:0] slot_q;

	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;
	logic [31:0] h32;

	always_comb begin
		unique case (state_q)
			H_MUL1: begin
				op_a = a_q[63:32];
				op_b = pidd_pkg::HASH_MUL_LO;
			end
			H_MUL2: begin
				op_a = a_q[31:0];
				op_b = pidd_pkg::HASH_MUL_HI;
			end
			H_QUOT: begin
				op_a = h_q;
				op_b = RECIP;
			end
			H_PROD: begin
				op_a = q_q;
				op_b = SLOTS32;
			end
			default: begin
				op_a = a_q[31:0];
				op_b = pidd_pkg::HASH_MUL_LO;
			end
		endcase
	end

	assign prod = op_a * op_b;

	// Only the low word of the final shift-xor is needed.
	assign h32 = p_q[31:0] ^ {1'b0, p_q[63:33]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (start) begin
						state_q <= H_MUL0;
					end
				end
				H_MUL0: state_q <= H_MUL1;
				H_MUL1: state_q <= H_MUL2;
				H_MUL2: state_q <= H_FOLD;
				H_FOLD: begin
					if (POW2) begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end else begin
						state_q <= H_QUOT;
					end
				end
				H_QUOT: state_q <= H_PROD;
				H_PROD: state_q <= H_FIX;
				H_FIX: begin
					done_q  <= 1'b1;
					state_q <= H_IDLE;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			H_IDLE: begin
				if (start) begin
					a_q <= key ^ (key >> 33);
				end
			end
			H_MUL0: p_q <= prod;
			H_MUL1: p_q[63:32] <= p_q[63:32] + prod[31:0];
			H_MUL2: p_q[63:32] <= p_q[63:32] + prod[31:0];
			H_FOLD: begin
				h_q <= h32;
				if (POW2) begin
					slot_q <= h32[SW-1:0];
				end
			end
			H_QUOT: q_q <= prod[63:32];
			// The low word of the product is enough: the remainder is small.
			H_PROD: rem_q <= (SW+1)'(h_q - prod[31:0]);
			H_FIX: begin
				slot_q <= (rem_q >= MODULUS) ? SW'(rem_q - MODULUS) : rem_q[SW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign slot = slot_q;

endmodule

// ===== design/pidd_table.sv =====
// ----------------------------------------------------------------------------
// pidd_table
// Open-addressed slot memory with linear probing, the dense pair counter and
// the sticky overflow flag. Frame starts move to a new epoch; a clearing sweep
// runs after reset and whenever the epoch counter wraps.
// ----------------------------------------------------------------------------
module pidd_table #(
	parameter int TABLE_SLOTS = 2048,
	localparam int SW = $clog2(TABLE_SLOTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pidd_pkg::tbl_req_t    req,
	input  logic [SW-1:0]         home_slot,
	output pidd_pkg::tbl_rsp_t    rsp,
	output pidd_pkg::tbl_status_t status
);

	localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);

	localparam logic P_IDLE  = 1'b0;
	localparam logic P_PROBE = 1'b1;

	pidd_pkg::slot_entry_t slot_mem_q [TABLE_SLOTS];
	pidd_pkg::slot_entry_t rd_data_q;

	logic                 state_q;
	pidd_pkg::epoch_t     epoch_q;
	pidd_pkg::count_t     count_q;
	logic                 ovf_q;
	logic                 sweep_q;
	logic [SW-1:0]        sweep_addr_q;
	logic [SW-1:0]        probes_q;
	logic                 rsp_done_q;

	pidd_pkg::key_t       key_q;
	pidd_pkg::count_t     limit_q;
	logic [SW-1:0]        cur_q;
	pidd_pkg::index_t     rsp_idx_q;
	logic                 rsp_added_q;

	logic                 cur_used;
	logic                 hit;
	logic                 last_probe;
	logic                 room;
	logic [SW-1:0]        next_slot;
	logic                 rd_en;
	logic [SW-1:0]        rd_addr;
	logic                 wr_en;
	logic [SW-1:0]        wr_addr;
	pidd_pkg::slot_entry_t wr_data;

	assign cur_used   = rd_data_q.tag == epoch_q;
	assign hit        = cur_used && (rd_data_q.key == key_q);
	assign last_probe = probes_q == LAST_SLOT;
	assign room       = count_q < limit_q;
	assign next_slot  = (cur_q == LAST_SLOT) ? '0 : cur_q + 1'b1;

	// While probing, the following slot is read every cycle so that one slot is
	// examined per cycle. Lookups write only at their end, the next lookup waits for a new
	// hash, and sweeps run only while no lookup is issued, so reads and writes never collide.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = home_slot;
		if (state_q == P_IDLE && req.lookup) begin
			rd_en = 1'b1;
		end else if (state_q == P_PROBE) begin
			rd_en   = 1'b1;
			rd_addr = next_slot;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = '{key: key_q, idx: count_q[pidd_pkg::INDEX_W-1:0], tag: epoch_q};
		if (sweep_q) begin
			wr_en   = 1'b1;
			wr_addr = sweep_addr_q;
			wr_data = '0;
		end else if (state_q == P_PROBE && !cur_used && room) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= slot_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= P_IDLE;
			epoch_q      <= pidd_pkg::EPOCH_W'(1);
			count_q      <= '0;
			ovf_q        <= 1'b0;
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
			probes_q     <= '0;
			rsp_done_q   <= 1'b0;
		end else begin
			rsp_done_q <= 1'b0;

			if (sweep_q) begin
				if (sweep_addr_q == LAST_SLOT) begin
					sweep_q <= 1'b0;
				end else begin
					sweep_addr_q <= sweep_addr_q + 1'b1;
				end
			end

			// Epoch zero is what the sweep writes, so it is never current.
			if (req.frame) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				if (epoch_q == '1) begin
					epoch_q      <= pidd_pkg::EPOCH_W'(1);
					sweep_q      <= 1'b1;
					sweep_addr_q <= '0;
				end else begin
					epoch_q <= epoch_q + 1'b1;
				end
			end

			unique case (state_q)
				P_IDLE: begin
					if (req.lookup) begin
						probes_q <= '0;
						state_q  <= P_PROBE;
					end
				end
				P_PROBE: begin
					if (!cur_used) begin
						if (room) begin
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						rsp_done_q <= 1'b1;
						state_q    <= P_IDLE;
					end else if (hit) begin
						rsp_done_q <= 1'b1;
						state_q    <= P_IDLE;
					end else if (last_probe) begin
						// Every slot holds another key: treated as at the limit.
						ovf_q      <= 1'b1;
						rsp_done_q <= 1'b1;
						state_q    <= P_IDLE;
					end else begin
						probes_q <= probes_q + 1'b1;
					end
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == P_IDLE) begin
			if (req.lookup) begin
				key_q   <= req.key;
				limit_q <= req.limit;
				cur_q   <= home_slot;
			end
		end else begin
			cur_q <= next_slot;
			if (!cur_used) begin
				rsp_idx_q   <= room ? count_q[pidd_pkg::INDEX_W-1:0] : '0;
				rsp_added_q <= room;
			end else if (hit) begin
				rsp_idx_q   <= rd_data_q.idx;
				rsp_added_q <= 1'b0;
			end else begin
				rsp_idx_q   <= '0;
				rsp_added_q <= 1'b0;
			end
		end
	end

	assign rsp.done        = rsp_done_q;
	assign rsp.index       = rsp_idx_q;
	assign rsp.added       = rsp_added_q;
	assign status.sweeping = sweep_q;
	assign status.overflow = ovf_q;

endmodule

// ===== test/pixel_id_pair_deduplicator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_id_pair_deduplicator_checker
// Watches the pixel, result and limit channels of the deduplicator. It keeps
// its own hash table of id pairs, predicts the result of every accepted pixel
// and compares each result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module pixel_id_pair_deduplicator_checker #(
	parameter int MAX_PAIRS   = 1024,
	parameter int TABLE_SLOTS = 2048
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic                       frame_start,
	input  logic signed [31:0]         prim_id,
	input  logic signed [31:0]         inst_id,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  pidd_pkg::count_t           cfg_data,
	input  logic                       done,
	input  pidd_pkg::index_t           identity_index,
	input  logic                       is_background,
	input  logic                       newly_added,
	input  logic                       overflow,
	output int                         error_count,
	output int                         results_seen
);

	typedef struct packed {
		pidd_pkg::index_t index;
		logic             background;
		logic             added;
		logic             overflow;
	} identity_result_t;

	pidd_pkg::key_t   slot_key [TABLE_SLOTS];
	pidd_pkg::index_t slot_idx [TABLE_SLOTS];
	bit               slot_used [TABLE_SLOTS];
	pidd_pkg::count_t pair_count;
	bit               overflow_seen;
	pidd_pkg::count_t limit_reg;
	identity_result_t expected_q [$];
	int               mismatches;
	int               result_no;

	// Home slot of a key: shift-xor, multiply, shift-xor, low word modulo the table.
	function automatic int home_slot(input pidd_pkg::key_t key);
		logic [63:0] h;
		h = key ^ (key >> 33);
		h = h * {pidd_pkg::HASH_MUL_HI, pidd_pkg::HASH_MUL_LO};
		h = h ^ (h >> 33);
		return int'(h[31:0] % TABLE_SLOTS);
	endfunction

	function automatic void clear_frame();
		for (int i = 0; i < TABLE_SLOTS; i++)
			slot_used[i] = 1'b0;
		pair_count    = '0;
		overflow_seen = 1'b0;
	endfunction

	function automatic identity_result_t lookup_pixel(input logic fs, input logic [31:0] prim,
			input logic [31:0] inst);
		identity_result_t r;
		pidd_pkg::key_t   key;
		int               slot;
		int               probes;
		pidd_pkg::count_t lim;
		logic             hit;
		logic             hole;
		r = '0;
		if (fs)
			clear_frame();
		if (prim == pidd_pkg::BG_PRIM) begin
			r.background = 1'b1;
		end else begin
			key    = {prim, inst};
			slot   = home_slot(key);
			lim    = (int'(limit_reg) > MAX_PAIRS) ? pidd_pkg::count_t'(MAX_PAIRS) : limit_reg;
			hit    = 1'b0;
			hole   = 1'b0;
			probes = 0;
			while (probes < TABLE_SLOTS && !hit && !hole) begin
				if (!slot_used[slot]) begin
					hole = 1'b1;
				end else if (slot_key[slot] == key) begin
					hit = 1'b1;
				end else begin
					slot = (slot + 1) % TABLE_SLOTS;
					probes++;
				end
			end
			if (hit) begin
				r.index = slot_idx[slot];
			end else if (hole && pair_count < lim) begin
				slot_key[slot]  = key;
				slot_idx[slot]  = pair_count[pidd_pkg::INDEX_W-1:0];
				slot_used[slot] = 1'b1;
				r.index         = pair_count[pidd_pkg::INDEX_W-1:0];
				r.added         = 1'b1;
				pair_count++;
			end else begin
				// Refused pair: limit in force reached, or no free slot left.
				overflow_seen = 1'b1;
			end
		end
		r.overflow = overflow_seen;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		identity_result_t seen;
		identity_result_t want;
		identity_result_t pred;
		if (!arst_n) begin
			clear_frame();
			limit_reg = pidd_pkg::count_t'(1024);
			expected_q.delete();
			mismatches = 0;
			result_no  = 0;
			error_count  <= 0;
			results_seen <= 0;
		end else begin
			// A result never belongs to a pixel taken at the same edge, so check first.
			if (done) begin
				seen = '{identity_index, is_background, newly_added, overflow};
				if (expected_q.size() == 0) begin
					if (mismatches < 10)
						$display("Result %0d arrived with no pixel outstanding", result_no);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					if (seen != want) begin
						if (mismatches < 10)
							$display({"Mismatch on result %0d: expected index %0d bg %b ",
								"new %b ovf %b, got index %0d bg %b new %b ovf %b"},
								result_no, want.index, want.background, want.added,
								want.overflow, seen.index, seen.background, seen.added,
								seen.overflow);
						mismatches++;
					end
				end
				result_no++;
			end
			if (cfg_valid && cfg_ready)
				limit_reg = cfg_data;
			if (start && !busy) begin
				pred       = lookup_pixel(frame_start, prim_id, inst_id);
				expected_q = {expected_q, pred};
			end
			error_count  <= mismatches;
			results_seen <= result_no;
		end
	end

endmodule

// ===== test/pixel_id_pair_deduplicator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_id_pair_deduplicator_tb
// Drives pixels and limit writes into the deduplicator: a directed opening
// (field extremes, background, limit reached, zero limit, clamped limit,
// probe chains wrapping round the table) and then random phases under
// several limits, ending with a frame that fills the table to its limit.
// ----------------------------------------------------------------------------
module pixel_id_pair_deduplicator_tb;

	localparam int MAX_PAIRS   = 1024;
	localparam int TABLE_SLOTS = 2048;
	localparam int CYCLE_LIMIT = 1_000_000;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               start       = 1'b0;
	logic               frame_start = 1'b0;
	logic signed [31:0] prim_id     = '0;
	logic signed [31:0] inst_id     = '0;
	logic               cfg_valid   = 1'b0;
	pidd_pkg::count_t   cfg_data    = '0;
	logic               busy;
	logic               cfg_ready;
	logic               done;
	pidd_pkg::index_t   identity_index;
	logic               is_background;
	logic               newly_added;
	logic               overflow;

	int error_count;
	int results_seen;
	int pixels_sent = 0;
	int gap_pct     = 32;
	int cycle_count = 0;

	always #6 clk = ~clk;

	pixel_id_pair_deduplicator #(
		.MAX_PAIRS   (MAX_PAIRS),
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.frame_start    (frame_start),
		.prim_id        (prim_id),
		.inst_id        (inst_id),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.identity_index (identity_index),
		.is_background  (is_background),
		.newly_added    (newly_added),
		.overflow       (overflow)
	);

	pixel_id_pair_deduplicator_checker #(
		.MAX_PAIRS   (MAX_PAIRS),
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.frame_start    (frame_start),
		.prim_id        (prim_id),
		.inst_id        (inst_id),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.identity_index (identity_index),
		.is_background  (is_background),
		.newly_added    (newly_added),
		.overflow       (overflow),
		.error_count    (error_count),
		.results_seen   (results_seen)
	);

	// Start is left high on return; the caller either drives the next pixel or lowers it.
	task automatic send_pixel(input logic fs, input pidd_pkg::key_t key);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		frame_start <= fs;
		prim_id     <= key[63:32];
		inst_id     <= key[31:0];
		do @(posedge clk); while (busy);
		pixels_sent++;
	endtask

	// The limit is only written once every outstanding pixel has produced its result.
	task automatic write_limit(input pidd_pkg::count_t value);
		start <= 1'b0;
		@(posedge clk);
		while (results_seen < pixels_sent)
			@(posedge clk);
		while ($urandom_range(0, 99) < gap_pct)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic pidd_pkg::key_t random_key();
		pidd_pkg::key_t k;
		do k = {$urandom, $urandom}; while (k[63:32] == pidd_pkg::BG_PRIM);
		return k;
	endfunction

	function automatic pidd_pkg::key_t key_at_slot(input int target);
		pidd_pkg::key_t k;
		do k = random_key(); while (u_chk.home_slot(k) != target);
		return k;
	endfunction

	function automatic pidd_pkg::key_t background_key();
		return {pidd_pkg::BG_PRIM, 32'($urandom)};
	endfunction

	// Each phase opens a frame, then mixes pooled pairs (repeats) with background and noise.
	task automatic run_phase(input pidd_pkg::count_t lim, input int n_pixels, input int fs_pct,
			input int pool_n);
		pidd_pkg::key_t pool [$];
		int             pick;
		logic           fs;
		write_limit(lim);
		repeat (pool_n) pool = {pool, random_key()};
		for (int i = 0; i < n_pixels; i++) begin
			fs   = (i == 0) || ($urandom_range(0, 99) < fs_pct);
			pick = $urandom_range(0, 99);
			if (pick < 10)
				send_pixel(fs, background_key());
			else if (pick < 22)
				send_pixel(fs, {$urandom, $urandom});
			else
				send_pixel(fs, pool[$urandom_range(0, pool_n - 1)]);
		end
	endtask

	// Fills one frame past the given limit, revisiting earlier pairs now and then.
	task automatic fill_table(input pidd_pkg::count_t lim, input int n_new);
		pidd_pkg::key_t seen [$];
		pidd_pkg::key_t k;
		write_limit(lim);
		for (int i = 0; i < n_new; i++) begin
			k    = random_key();
			seen = {seen, k};
			send_pixel(i == 0, k);
			if (i % 8 == 7)
				send_pixel(1'b0, seen[$urandom_range(0, seen.size() - 1)]);
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		pidd_pkg::key_t c0;
		pidd_pkg::key_t c1;
		pidd_pkg::key_t c2;
		pidd_pkg::key_t d0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Small limit: extremes of the ids, background, repeats, then a refused pair.
		write_limit(pidd_pkg::count_t'(4));
		send_pixel(1'b1, {32'h0000_0000, 32'h0000_0000});
		send_pixel(1'b0, {32'h7FFF_FFFF, 32'h8000_0000});
		send_pixel(1'b0, {32'h8000_0000, 32'h7FFF_FFFF});
		send_pixel(1'b0, {pidd_pkg::BG_PRIM, 32'h1234_5678});
		send_pixel(1'b0, {32'h0000_0000, 32'h0000_0000});
		send_pixel(1'b0, {32'hFFFF_FFFE, 32'hFFFF_FFFF});
		send_pixel(1'b0, {32'h0000_0005, 32'h0000_0005});
		send_pixel(1'b0, {32'h7FFF_FFFF, 32'h8000_0000});
		send_pixel(1'b0, {pidd_pkg::BG_PRIM, 32'h0000_0000});
		send_pixel(1'b1, {32'h0000_0005, 32'h0000_0005});

		// Zero limit: every pair is refused; background still keeps the sticky flag.
		write_limit(pidd_pkg::count_t'(0));
		send_pixel(1'b1, {32'h0000_0001, 32'h0000_0002});
		send_pixel(1'b0, {pidd_pkg::BG_PRIM, 32'hFFFF_FFFF});

		// Limit above the maximum, with a probe chain wrapping from the last slot to the first.
		c0 = key_at_slot(TABLE_SLOTS - 1);
		c1 = key_at_slot(TABLE_SLOTS - 1);
		c2 = key_at_slot(TABLE_SLOTS - 1);
		d0 = key_at_slot(0);
		write_limit(pidd_pkg::count_t'(2047));
		send_pixel(1'b1, c0);
		send_pixel(1'b0, c1);
		send_pixel(1'b0, c2);
		send_pixel(1'b0, d0);
		send_pixel(1'b0, c2);
		send_pixel(1'b0, c0);
		send_pixel(1'b0, d0);
		send_pixel(1'b0, background_key());

		run_phase(pidd_pkg::count_t'(1), 30, 5, 3);
		gap_pct = 0;
		run_phase(pidd_pkg::count_t'(17), 60, 3, 30);
		gap_pct = 32;
		run_phase(pidd_pkg::count_t'(1024), 80, 2, 200);
		run_phase(pidd_pkg::count_t'($urandom_range(0, 2047)), 50, 5, 40);
		// One-pixel frames, enough to cycle through the table's frame tags.
		run_phase(pidd_pkg::count_t'(2), 260, 100, 6);
		run_phase(pidd_pkg::count_t'(600), 80, 2, 500);
		fill_table(pidd_pkg::count_t'(100), 110);

		start <= 1'b0;
		while (results_seen < pixels_sent)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
